### hdl/pcr_pkg.sv
// Package for the polyline corner rounder: command and result codes,
// payload structs and sizing constants. No dependencies.
package pcr_pkg;

	localparam int CoordBits  = 32;
	localparam int RadiusBits = 31;
	localparam int CmdDepth   = 2;
	localparam int ResDepth   = 4;

	localparam logic [2:0] OP_MOVE  = 3'd0;
	localparam logic [2:0] OP_LINE  = 3'd1;
	localparam logic [2:0] OP_QUAD  = 3'd2;
	localparam logic [2:0] OP_CUBIC = 3'd3;
	localparam logic [2:0] OP_CLOSE = 3'd4;
	localparam logic [2:0] OP_DONE  = 3'd5;

	localparam logic [1:0] EMIT_MOVE  = 2'd0;
	localparam logic [1:0] EMIT_LINE  = 2'd1;
	localparam logic [1:0] EMIT_QUAD  = 2'd2;
	localparam logic [1:0] EMIT_CLOSE = 2'd3;

	typedef struct packed {
		logic [2:0]                  op;
		logic                        contour_closed;
		logic signed [CoordBits-1:0] point_x;
		logic signed [CoordBits-1:0] point_y;
	} pcr_cmd_t;

	typedef struct packed {
		logic [1:0]                  out_op;
		logic signed [CoordBits-1:0] ctrl_x;
		logic signed [CoordBits-1:0] ctrl_y;
		logic signed [CoordBits-1:0] end_x;
		logic signed [CoordBits-1:0] end_y;
		logic                        last;
	} pcr_res_t;

	typedef struct packed {
		logic signed [CoordBits:0] dx;
		logic signed [CoordBits:0] dy;
	} pcr_step_req_t;

	typedef struct packed {
		logic signed [CoordBits-1:0] step_x;
		logic signed [CoordBits-1:0] step_y;
		logic                        draw;
	} pcr_step_res_t;

endpackage

### hdl/pcr_front.sv
// Front end: accepts commands, drops those with no effect, queues the rest.
// Depends on pcr_pkg.
module pcr_front #(
	parameter int DEPTH = pcr_pkg::CmdDepth
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pcr_pkg::pcr_cmd_t                 cmd,
	input  logic                              push,
	output logic                              full,
	input  logic [pcr_pkg::RadiusBits-1:0]    corner_radius,
	output pcr_pkg::pcr_cmd_t                 q_cmd,
	output logic                              q_valid,
	input  logic                              q_pop
);
	import pcr_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	pcr_cmd_t            mem_q [DEPTH];
	logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                keep, wr, rd;

	assign keep    = (corner_radius != '0) && (cmd.op <= OP_DONE);
	assign full    = (count_q == CntW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign wr      = push && !full && keep;
	assign rd      = q_pop && q_valid;
	assign q_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/pcr_step_unit.sv
// Iterative step vector unit: magnitude scaling, bit-serial square root and
// two restoring dividers. Depends on pcr_pkg.
module pcr_step_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  pcr_pkg::pcr_step_req_t         req,
	input  logic [pcr_pkg::RadiusBits-1:0] radius,
	output logic                           done,
	output pcr_pkg::pcr_step_res_t         res
);
	import pcr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SQ, S_SUM, S_ROOT, S_CMP, S_MUL, S_DINIT, S_DIV, S_FORM
	} state_t;

	state_t          state_q;
	logic            done_q;
	pcr_step_res_t   res_q;
	logic            nx_q, ny_q;
	logic [1:0]      k_q;
	logic [30:0]     sx_q, sy_q, r_q;
	logic [31:0]     hx_q, hy_q;
	logic [61:0]     sqx_q, sqy_q, px_q, py_q;
	logic [63:0]     rad_q, res_root_q, bit_q;
	logic [4:0]      cnt_q;
	logic [31:0]     remx_q, remy_q;
	logic [30:0]     lowx_q, lowy_q, qx_q, qy_q;

	logic [32:0]     mx, my;
	logic [1:0]      kc;
	logic [63:0]     root_t;
	logic            root_ge;
	logic [31:0]     d;
	logic            short_seg;
	logic [32:0]     tx, ty;
	logic            gex, gey;

	always_comb begin
		mx = req.dx[32] ? (33'd0 - req.dx) : req.dx;
		my = req.dy[32] ? (33'd0 - req.dy) : req.dy;
		if (mx[32] || my[32]) begin
			kc = 2'd2;
		end else if (mx[31] || my[31]) begin
			kc = 2'd1;
		end else begin
			kc = 2'd0;
		end
		root_t    = res_root_q + bit_q;
		root_ge   = rad_q >= root_t;
		d         = res_root_q[31:0];
		short_seg = (d == '0) || (({2'b0, d} << k_q) <= {2'b0, r_q, 1'b0});
		tx        = {remx_q, lowx_q[30]};
		ty        = {remy_q, lowy_q[30]};
		gex       = tx >= {1'b0, d};
		gey       = ty >= {1'b0, d};
	end

	assign done = done_q;
	assign res  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						nx_q    <= req.dx[32];
						ny_q    <= req.dy[32];
						hx_q    <= req.dx[32:1];
						hy_q    <= req.dy[32:1];
						k_q     <= kc;
						sx_q    <= 31'(mx >> kc);
						sy_q    <= 31'(my >> kc);
						r_q     <= radius;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					sqx_q   <= sx_q * sx_q;
					sqy_q   <= sy_q * sy_q;
					state_q <= S_SUM;
				end
				S_SUM: begin
					rad_q      <= 64'(sqx_q) + 64'(sqy_q);
					res_root_q <= '0;
					bit_q      <= 64'd1 << 62;
					cnt_q      <= '0;
					state_q    <= S_ROOT;
				end
				S_ROOT: begin
					if (root_ge) begin
						rad_q      <= rad_q - root_t;
						res_root_q <= (res_root_q >> 1) + bit_q;
					end else begin
						res_root_q <= res_root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd31) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (short_seg) begin
						res_q.step_x <= hx_q;
						res_q.step_y <= hy_q;
						res_q.draw   <= 1'b0;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					px_q    <= sx_q * r_q;
					py_q    <= sy_q * r_q;
					state_q <= S_DINIT;
				end
				S_DINIT: begin
					remx_q  <= {1'b0, px_q[61:31]};
					remy_q  <= {1'b0, py_q[61:31]};
					lowx_q  <= px_q[30:0];
					lowy_q  <= py_q[30:0];
					qx_q    <= '0;
					qy_q    <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					remx_q <= gex ? 32'(tx - {1'b0, d}) : tx[31:0];
					remy_q <= gey ? 32'(ty - {1'b0, d}) : ty[31:0];
					lowx_q <= lowx_q << 1;
					lowy_q <= lowy_q << 1;
					qx_q   <= {qx_q[29:0], gex};
					qy_q   <= {qy_q[29:0], gey};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == 5'd30) begin
						state_q <= S_FORM;
					end
				end
				S_FORM: begin
					res_q.step_x <= nx_q ? (32'd0 - {1'b0, qx_q}) : {1'b0, qx_q};
					res_q.step_y <= ny_q ? (32'd0 - {1'b0, qy_q}) : {1'b0, qy_q};
					res_q.draw   <= 1'b1;
					done_q       <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### hdl/pcr_back.sv
// Back end: path state, command execution and the result queue.
// Depends on pcr_pkg and pcr_step_unit.
module pcr_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pcr_pkg::pcr_cmd_t              q_cmd,
	input  logic                           q_valid,
	output logic                           q_pop,
	input  logic [pcr_pkg::RadiusBits-1:0] corner_radius,
	output pcr_pkg::pcr_res_t              result,
	output logic                           empty,
	input  logic                           pop
);
	import pcr_pkg::*;

	localparam int PtrW = $clog2(ResDepth);
	localparam int CntW = $clog2(ResDepth + 1);

	typedef enum logic {B_IDLE, B_LINE} state_t;

	typedef logic signed [CoordBits-1:0] coord_t;

	state_t          state_q;
	coord_t          cur_x_q, cur_y_q, start_x_q, start_y_q, corner_x_q, corner_y_q;
	coord_t          step_x_q, step_y_q, first_x_q, first_y_q, lx_q, ly_q;
	logic            prev_valid_q, prev_was_move_q;

	pcr_res_t        mem_q [ResDepth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	logic            room, take, rd, step_start, step_done;
	pcr_step_req_t   step_req;
	pcr_step_res_t   step_res;
	pcr_res_t        res0, res1;
	logic [1:0]      nres;

	function automatic pcr_res_t mk(logic [1:0] op, coord_t cx, coord_t cy,
			coord_t ex, coord_t ey, logic lst);
		pcr_res_t r;
		r.out_op = op;
		r.ctrl_x = cx;
		r.ctrl_y = cy;
		r.end_x  = ex;
		r.end_y  = ey;
		r.last   = lst;
		return r;
	endfunction

	pcr_step_unit u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (step_start),
		.req    (step_req),
		.radius (corner_radius),
		.done   (step_done),
		.res    (step_res)
	);

	assign room       = (count_q <= CntW'(ResDepth - 2));
	assign take       = (state_q == B_IDLE) && q_valid && room;
	assign q_pop      = take;
	assign step_start = take && (q_cmd.op == OP_LINE);
	assign step_req.dx = {q_cmd.point_x[CoordBits-1], q_cmd.point_x}
			- {cur_x_q[CoordBits-1], cur_x_q};
	assign step_req.dy = {q_cmd.point_y[CoordBits-1], q_cmd.point_y}
			- {cur_y_q[CoordBits-1], cur_y_q};
	assign empty      = (count_q == '0);
	assign result     = mem_q[rd_ptr_q];
	assign rd         = pop && !empty;

	always_comb begin
		res0 = '0;
		res1 = '0;
		nres = 2'd0;
		if (take) begin
			case (q_cmd.op)
				OP_MOVE: begin
					if (!q_cmd.contour_closed) begin
						res0 = mk(EMIT_MOVE, '0, '0, q_cmd.point_x, q_cmd.point_y, 1'b1);
						nres = 2'd1;
					end
				end
				OP_CLOSE: begin
					res0 = mk(EMIT_QUAD, corner_x_q, corner_y_q,
						corner_x_q + first_x_q, corner_y_q + first_y_q, 1'b0);
					res1 = mk(EMIT_CLOSE, '0, '0, '0, '0, 1'b1);
					nres = 2'd2;
				end
				default: begin
					nres = 2'd0;
				end
			endcase
		end else if (state_q == B_LINE && step_done) begin
			if (prev_valid_q) begin
				res0 = mk(EMIT_QUAD, cur_x_q, cur_y_q, cur_x_q + step_res.step_x,
					cur_y_q + step_res.step_y, !step_res.draw);
			end else begin
				res0 = mk(EMIT_MOVE, '0, '0, start_x_q + step_res.step_x,
					start_y_q + step_res.step_y, !step_res.draw);
			end
			res1 = mk(EMIT_LINE, '0, '0, lx_q - step_res.step_x,
				ly_q - step_res.step_y, 1'b1);
			nres = step_res.draw ? 2'd2 : 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (nres != 2'd0) begin
			mem_q[wr_ptr_q] <= res0;
		end
		if (nres == 2'd2) begin
			mem_q[wr_ptr_q + 1'b1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrW'(nres);
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CntW'(nres) - CntW'(rd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= B_IDLE;
			cur_x_q         <= '0;
			cur_y_q         <= '0;
			start_x_q       <= '0;
			start_y_q       <= '0;
			corner_x_q      <= '0;
			corner_y_q      <= '0;
			step_x_q        <= '0;
			step_y_q        <= '0;
			first_x_q       <= '0;
			first_y_q       <= '0;
			lx_q            <= '0;
			ly_q            <= '0;
			prev_valid_q    <= 1'b1;
			prev_was_move_q <= 1'b0;
		end else if (take) begin
			case (q_cmd.op)
				OP_MOVE: begin
					cur_x_q      <= q_cmd.point_x;
					cur_y_q      <= q_cmd.point_y;
					start_x_q    <= q_cmd.point_x;
					start_y_q    <= q_cmd.point_y;
					prev_valid_q <= !q_cmd.contour_closed;
					if (prev_was_move_q) begin
						first_x_q <= step_x_q;
						first_y_q <= step_y_q;
					end
					prev_was_move_q <= 1'b1;
				end
				OP_LINE: begin
					lx_q    <= q_cmd.point_x;
					ly_q    <= q_cmd.point_y;
					state_q <= B_LINE;
				end
				OP_QUAD, OP_CUBIC: begin
					cur_x_q <= q_cmd.point_x;
					cur_y_q <= q_cmd.point_y;
					if (prev_was_move_q) begin
						first_x_q <= step_x_q;
						first_y_q <= step_y_q;
					end
					prev_was_move_q <= 1'b0;
				end
				OP_CLOSE: begin
					cur_x_q <= start_x_q;
					cur_y_q <= start_y_q;
					if (prev_was_move_q) begin
						first_x_q <= step_x_q;
						first_y_q <= step_y_q;
					end
					prev_was_move_q <= 1'b0;
				end
				OP_DONE: begin
					cur_x_q         <= '0;
					cur_y_q         <= '0;
					start_x_q       <= '0;
					start_y_q       <= '0;
					corner_x_q      <= '0;
					corner_y_q      <= '0;
					step_x_q        <= '0;
					step_y_q        <= '0;
					first_x_q       <= '0;
					first_y_q       <= '0;
					prev_valid_q    <= 1'b1;
					prev_was_move_q <= 1'b0;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end else if (state_q == B_LINE && step_done) begin
			step_x_q     <= step_res.step_x;
			step_y_q     <= step_res.step_y;
			prev_valid_q <= 1'b1;
			corner_x_q   <= lx_q;
			corner_y_q   <= ly_q;
			cur_x_q      <= lx_q;
			cur_y_q      <= ly_q;
			if (prev_was_move_q) begin
				first_x_q <= step_res.step_x;
				first_y_q <= step_res.step_y;
			end
			prev_was_move_q <= 1'b0;
			state_q         <= B_IDLE;
		end
	end

endmodule

### hdl/polyline_corner_rounder.sv
// Polyline corner rounder top level: radius register, front end, back end.
// A line gives its results once the step unit has run its 32-step square root and,
// unless the segment is short, its 31-step dividers. An open-contour MOVE and a CLOSE
// give results in the cycle after their transfer; other commands give none. No command
// is taken during a line; others go one per cycle while the result queue has room.
// Reset: arst_n clears path state, queues and the radius (block off).
module polyline_corner_rounder #(
	parameter int CMD_DEPTH = pcr_pkg::CmdDepth
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           radius_we,
	input  logic [pcr_pkg::RadiusBits-1:0] radius_wdata,
	input  pcr_pkg::pcr_cmd_t              cmd,
	input  logic                           push,
	output logic                           full,
	output pcr_pkg::pcr_res_t              result,
	output logic                           empty,
	input  logic                           pop
);
	import pcr_pkg::*;

	logic [RadiusBits-1:0] corner_radius_q;
	pcr_cmd_t              q_cmd;
	logic                  q_valid, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_radius_q <= '0;
		end else if (radius_we) begin
			corner_radius_q <= radius_wdata;
		end
	end

	pcr_front #(.DEPTH(CMD_DEPTH)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.push          (push),
		.full          (full),
		.corner_radius (corner_radius_q),
		.q_cmd         (q_cmd),
		.q_valid       (q_valid),
		.q_pop         (q_pop)
	);

	pcr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_cmd         (q_cmd),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.corner_radius (corner_radius_q),
		.result        (result),
		.empty         (empty),
		.pop           (pop)
	);

`ifndef SYNTHESIS
	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.out_op == EMIT_CLOSE) |-> result.last)
		else $error("close result without last");
	a_close_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.out_op == EMIT_CLOSE) |->
		(result.end_x == 0 && result.end_y == 0 && result.ctrl_x == 0))
		else $error("close result carries coordinates");
	a_pop_only_queued: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back end took from an empty command queue");
`endif

endmodule
